/* sv/dmn_pkg.sv */
// Shared types and constants of the distributed mutex node.
`timescale 1ns / 1ps

package dmn_pkg;

  // Field widths fixed by the message format.
  localparam int KIND_W      = 2;
  localparam int PEER_W      = 4;
  localparam int SEQ_FIELD_W = 16;
  localparam int ACT_W       = 2;
  localparam int NODE_ID_W   = 4;
  localparam int NODE_CNT_W  = 5;
  localparam int CFG_W       = 5;
  localparam int CFG_IDX_W   = 1;

  // Peer indices are carried in four bits, so at most sixteen peers are tracked.
  localparam int PEER_LIMIT = 16;

  // Input kinds.
  localparam logic [KIND_W-1:0] KIND_LOCAL_REQ = 2'd0;
  localparam logic [KIND_W-1:0] KIND_LOCAL_REL = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REPLY_RX  = 2'd2;
  localparam logic [KIND_W-1:0] KIND_REQ_RX    = 2'd3;

  // Output actions.
  localparam logic [ACT_W-1:0] ACT_REQUEST = 2'd0;
  localparam logic [ACT_W-1:0] ACT_REPLY   = 2'd1;
  localparam logic [ACT_W-1:0] ACT_GRANT   = 2'd2;
  localparam logic [ACT_W-1:0] ACT_NOTHING = 2'd3;

  // Configuration register indices and reset values.
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_ID    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_NODE_COUNT = 1'd1;
  localparam logic [NODE_ID_W-1:0]  NODE_ID_RST    = 4'd0;
  localparam logic [NODE_CNT_W-1:0] NODE_COUNT_RST = 5'd16;

  typedef struct packed {
    logic [KIND_W-1:0]      kind;
    logic [PEER_W-1:0]      peer;
    logic [SEQ_FIELD_W-1:0] their_seq;
  } in_item_t;

  typedef struct packed {
    logic [ACT_W-1:0]       action;
    logic [PEER_W-1:0]      dest;
    logic [SEQ_FIELD_W-1:0] msg_seq;
    logic                   busy_res;
    logic                   last;
  } out_item_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic start;
    logic emit_walk;
    logic emit_tail;
    logic advance;
  } ctrl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic mask_empty;
    logic bit_set;
    logic tail_pending;
    logic slot_free;
  } ctrl_sts_t;

endpackage

/* sv/dmn_ctrl.sv */
// Controller state machine of the distributed mutex node.
`timescale 1ns / 1ps

module dmn_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  dmn_pkg::ctrl_sts_t sts_i,
  output dmn_pkg::ctrl_cmd_t cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_WALK = 1'b1;

  logic state_q;
  logic state_d;

  always_comb begin
    cmd_o   = '0;
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.start = 1'b1;
          state_d     = ST_WALK;
        end
      end
      ST_WALK: begin
        if (!sts_i.mask_empty) begin
          // Peers without a message are passed over; a message waits for a free slot.
          if (!sts_i.bit_set) begin
            cmd_o.advance = 1'b1;
          end else if (sts_i.slot_free) begin
            cmd_o.emit_walk = 1'b1;
            cmd_o.advance   = 1'b1;
          end
        end else if (!sts_i.tail_pending) begin
          state_d = ST_IDLE;
        end else if (sts_i.slot_free) begin
          cmd_o.emit_tail = 1'b1;
          state_d         = ST_IDLE;
        end
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_stall_o = (state_q == ST_WALK);

endmodule

/* sv/dmn_datapath.sv */
// Datapath of the distributed mutex node: protocol state, peer walk and output register.
`timescale 1ns / 1ps

module dmn_datapath #(
  parameter int MAX_NODES = 16,
  parameter int SEQ_BITS  = 16
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [dmn_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [dmn_pkg::CFG_W-1:0]           cfg_data_i,
  input  dmn_pkg::in_item_t                   in_data_i,
  input  dmn_pkg::ctrl_cmd_t                  cmd_i,
  output dmn_pkg::ctrl_sts_t                  sts_o,
  output logic                                out_valid_o,
  output dmn_pkg::out_item_t                  out_data_o,
  input  logic                                out_stall_i
);

  localparam int PEERS = (MAX_NODES < dmn_pkg::PEER_LIMIT) ? MAX_NODES : dmn_pkg::PEER_LIMIT;
  localparam int IDX_W = $clog2(PEERS);
  localparam int PW    = dmn_pkg::PEER_W;
  localparam int SW    = dmn_pkg::SEQ_FIELD_W;
  localparam int CW    = dmn_pkg::NODE_CNT_W;
  localparam int CMP_W = (SEQ_BITS > SW) ? SEQ_BITS : SW;
  localparam logic [SEQ_BITS-1:0] SEQ_MAX = {SEQ_BITS{1'b1}};

  // Configuration.
  logic [dmn_pkg::NODE_ID_W-1:0]  node_id_q;
  logic [dmn_pkg::NODE_CNT_W-1:0] node_count_q;

  // Protocol state.
  logic [SEQ_BITS-1:0] own_seq_q, own_seq_d;
  logic [SEQ_BITS-1:0] high_seq_q, high_seq_d;
  logic [PEERS-1:0]    perm_q, perm_d;
  logic [PEERS-1:0]    defer_q, defer_d;
  logic                waiting_q, waiting_d;
  logic                using_q, using_d;

  // Per-item work.
  logic [PEERS-1:0]            mask_q, mask_d;
  logic [dmn_pkg::ACT_W-1:0]   walk_act_q, walk_act_d;
  logic                        tail_v_q, tail_v_d;
  logic [dmn_pkg::ACT_W-1:0]   tail_act_q, tail_act_d;
  logic [PW-1:0]               tail_dest_q, tail_dest_d;
  logic                        busy_q, busy_d;
  logic [IDX_W-1:0]            idx_q;

  logic               out_valid_q;
  dmn_pkg::out_item_t out_q;

  logic [CW-1:0]       lim;
  logic [PEERS-1:0]    peers;
  logic [PEERS-1:0]    p_hot;
  logic [PEERS-1:0]    idx_hot;
  logic [PEERS-1:0]    mask_rest;
  logic                p_ok;
  logic                perm_p;
  logic                ours;
  logic                grant;
  logic                req_after;
  logic [CMP_W-1:0]    theirs_ext;
  logic [SEQ_BITS-1:0] theirs_sat;
  logic                slot_free;
  logic                last_walk;

  always_comb begin
    lim = (node_count_q > CW'(PEERS)) ? CW'(PEERS) : node_count_q;
    for (int j = 0; j < PEERS; j++) begin
      peers[j]   = (CW'(j) < lim) && (PW'(j) != node_id_q);
      p_hot[j]   = (in_data_i.peer == PW'(j));
      idx_hot[j] = (idx_q == IDX_W'(j));
    end
  end

  assign p_ok   = ({1'b0, in_data_i.peer} < lim) && (in_data_i.peer != node_id_q);
  assign perm_p = |(perm_q & p_hot);

  // A received sequence number beyond the counter range counts as its largest value.
  assign theirs_ext = CMP_W'(in_data_i.their_seq);
  assign theirs_sat = (theirs_ext > CMP_W'(SEQ_MAX)) ? SEQ_MAX : theirs_ext[SEQ_BITS-1:0];

  assign ours = (theirs_sat > own_seq_q) ||
                ((theirs_sat == own_seq_q) && (in_data_i.peer > node_id_q));

  always_comb begin
    own_seq_d  = own_seq_q;
    high_seq_d = high_seq_q;
    perm_d     = perm_q;
    defer_d    = defer_q;
    waiting_d  = waiting_q;
    using_d    = using_q;
    mask_d     = '0;
    walk_act_d = dmn_pkg::ACT_REQUEST;
    grant      = 1'b0;
    req_after  = 1'b0;
    unique case (in_data_i.kind)
      dmn_pkg::KIND_LOCAL_REQ: begin
        if (!waiting_q && !using_q) begin
          waiting_d  = 1'b1;
          own_seq_d  = (&high_seq_q) ? high_seq_q : high_seq_q + 1'b1;
          mask_d     = peers & ~perm_q;
          walk_act_d = dmn_pkg::ACT_REQUEST;
          if (mask_d == '0) begin
            waiting_d = 1'b0;
            using_d   = 1'b1;
            grant     = 1'b1;
          end
        end
      end
      dmn_pkg::KIND_LOCAL_REL: begin
        if (using_q) begin
          using_d    = 1'b0;
          mask_d     = peers & defer_q;
          perm_d     = perm_q & ~mask_d;
          defer_d    = defer_q & ~mask_d;
          walk_act_d = dmn_pkg::ACT_REPLY;
        end
      end
      dmn_pkg::KIND_REPLY_RX: begin
        if (p_ok) begin
          perm_d = perm_q | p_hot;
          if (waiting_q && ((peers & ~perm_d) == '0)) begin
            waiting_d = 1'b0;
            using_d   = 1'b1;
            grant     = 1'b1;
          end
        end
      end
      dmn_pkg::KIND_REQ_RX: begin
        if (p_ok) begin
          if (theirs_sat > high_seq_q) begin
            high_seq_d = theirs_sat;
          end
          if (using_q || (waiting_q && ours)) begin
            defer_d = defer_q | p_hot;
          end
          walk_act_d = dmn_pkg::ACT_REPLY;
          if (!(using_q || waiting_q) || (waiting_q && !perm_p && !ours)) begin
            perm_d = perm_q & ~p_hot;
            mask_d = p_hot;
          end else if (waiting_q && perm_p && !ours) begin
            // A kept permission is handed back and asked for again at once.
            perm_d    = perm_q & ~p_hot;
            mask_d    = p_hot;
            req_after = 1'b1;
          end
        end
      end
    endcase
  end

  always_comb begin
    busy_d      = waiting_d | using_d;
    tail_v_d    = grant | req_after | (mask_d == '0);
    tail_dest_d = req_after ? in_data_i.peer : '0;
    if (grant) begin
      tail_act_d = dmn_pkg::ACT_GRANT;
    end else if (req_after) begin
      tail_act_d = dmn_pkg::ACT_REQUEST;
    end else begin
      tail_act_d = dmn_pkg::ACT_NOTHING;
    end
  end

  assign mask_rest = mask_q & ~idx_hot;
  assign last_walk = (mask_rest == '0) && !tail_v_q;
  assign slot_free = !out_valid_q || !out_stall_i;

  assign sts_o.mask_empty   = (mask_q == '0);
  assign sts_o.bit_set      = |(mask_q & idx_hot);
  assign sts_o.tail_pending = tail_v_q;
  assign sts_o.slot_free    = slot_free;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      node_id_q    <= dmn_pkg::NODE_ID_RST;
      node_count_q <= dmn_pkg::NODE_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        dmn_pkg::CFG_NODE_ID:    node_id_q    <= cfg_data_i[dmn_pkg::NODE_ID_W-1:0];
        dmn_pkg::CFG_NODE_COUNT: node_count_q <= cfg_data_i[dmn_pkg::NODE_CNT_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      own_seq_q  <= '0;
      high_seq_q <= '0;
      perm_q     <= '0;
      defer_q    <= '0;
      waiting_q  <= 1'b0;
      using_q    <= 1'b0;
      mask_q     <= '0;
      tail_v_q   <= 1'b0;
      idx_q      <= '0;
    end else if (cmd_i.start) begin
      own_seq_q  <= own_seq_d;
      high_seq_q <= high_seq_d;
      perm_q     <= perm_d;
      defer_q    <= defer_d;
      waiting_q  <= waiting_d;
      using_q    <= using_d;
      mask_q     <= mask_d;
      tail_v_q   <= tail_v_d;
      idx_q      <= '0;
    end else begin
      if (cmd_i.emit_walk) begin
        mask_q <= mask_rest;
      end
      if (cmd_i.advance) begin
        idx_q <= idx_q + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      walk_act_q  <= walk_act_d;
      tail_act_q  <= tail_act_d;
      tail_dest_q <= tail_dest_d;
      busy_q      <= busy_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit_walk || cmd_i.emit_tail) begin
      out_valid_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit_walk) begin
      out_q.action   <= walk_act_q;
      out_q.dest     <= PW'(idx_q);
      out_q.msg_seq  <= SW'(own_seq_q);
      out_q.busy_res <= busy_q;
      out_q.last     <= last_walk;
    end else if (cmd_i.emit_tail) begin
      out_q.action   <= tail_act_q;
      out_q.dest     <= tail_dest_q;
      out_q.msg_seq  <= (tail_act_q == dmn_pkg::ACT_REQUEST) ? SW'(own_seq_q) : '0;
      out_q.busy_res <= busy_q;
      out_q.last     <= 1'b1;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

/* sv/distributed_mutex_node_core.sv */
// Top level of one node of the distributed mutual exclusion protocol.
// Usage: the input channel carries one event per transfer (local request, local
// release, reply received or request received). The node answers each event with
// one or more result items on the output channel: messages to send, a grant once
// every peer's permission is held, or a single "nothing" item; the final item of
// an event has last set. Configuration (node index and node count) is written
// through the plain write port while the node is idle.
// Timing: an event is taken only while the node is idle. From the next cycle the
// controller inspects one peer index per cycle, from 0 up to the highest index that
// gets a message, pausing at an index with a message until the output register can
// take it; it then closes the event and loads the trailing grant, request or
// "nothing" item when there is one.
// A full output register holds its item while the receiver stalls; the walk then
// pauses until the register can be reloaded, and the input stays stalled until
// the last item of the event has been loaded.
// Reset clears all protocol state and sets node index 0 and node count 16.
`timescale 1ns / 1ps

module distributed_mutex_node_core #(
  parameter int MAX_NODES = 16,
  parameter int SEQ_BITS  = 16
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [dmn_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [dmn_pkg::CFG_W-1:0]     cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  dmn_pkg::in_item_t             in_data_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output dmn_pkg::out_item_t            out_data_o
);

  dmn_pkg::ctrl_cmd_t cmd;
  dmn_pkg::ctrl_sts_t sts;

  dmn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .sts_i      (sts),
    .cmd_o      (cmd)
  );

  dmn_datapath #(
    .MAX_NODES (MAX_NODES),
    .SEQ_BITS  (SEQ_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_data_i  (cfg_data_i),
    .in_data_i   (in_data_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o),
    .out_stall_i (out_stall_i)
  );

endmodule
